@@ rtl/bos_pkg.sv @@
// Package for the bounded overwrite stack: sizes, operation codes and the
// structs passed between the pointer logic and the top level. No dependencies.
package bos_pkg;

   localparam int DEPTH  = 16;
   localparam int WORD_W = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_TAKE = 2'd2;

   typedef struct packed {
      logic              we;
      logic [PTR_W-1:0]  waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [PTR_W-1:0]  raddr;
   } ram_req_type;

   typedef struct packed {
      logic             status;
      logic             data_valid;
      logic             evicted;
      logic [CNT_W-1:0] count;
      logic             full_res;
   } stage_type;

endpackage

@@ rtl/bos_if.sv @@
// Handshake channels of the bounded overwrite stack: request and response.
// Depends on bos_pkg for field widths.
interface bos_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                operation;
   logic [bos_pkg::WORD_W-1:0] value;

   modport source (output valid, operation, value, input ready);
   modport sink   (input valid, operation, value, output ready);
endinterface

interface bos_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                status;
   logic                                data_valid;
   logic                                evicted;
   logic [bos_pkg::WORD_W-1:0]          data_out;
   logic [bos_pkg::CNT_W-1:0]           count;
   logic                                full_res;

   modport source (output valid, status, data_valid, evicted, data_out, count, full_res,
                   input ready);
   modport sink   (input valid, status, data_valid, evicted, data_out, count, full_res,
                   output ready);
endinterface

@@ rtl/bos_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first on a same-address collision. No dependencies.
module bos_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bos_ctrl.sv @@
// Pointer and count logic of the bounded overwrite stack. Turns each accepted
// word into its RAM accesses, if any, and the status of its response. Uses bos_pkg.
module bos_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  operation,
   input  logic [bos_pkg::WORD_W-1:0]  value,
   output bos_pkg::ram_req_type        ram_req,
   output bos_pkg::stage_type          info
);
   import bos_pkg::*;

   logic [PTR_W-1:0] top_ff, top_in;
   logic [PTR_W-1:0] bottom_ff, bottom_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] top_next, top_prev, bottom_next;
   logic             is_full, is_empty;

   assign top_next    = (top_ff == PTR_LAST) ? '0 : top_ff + 1'b1;
   assign top_prev    = (top_ff == '0) ? PTR_LAST : top_ff - 1'b1;
   assign bottom_next = (bottom_ff == PTR_LAST) ? '0 : bottom_ff + 1'b1;
   assign is_full     = (count_ff == CNT_FULL);
   assign is_empty    = (count_ff == '0);

   always_comb begin
      top_in          = top_ff;
      bottom_in       = bottom_ff;
      count_in        = count_ff;
      ram_req.we      = 1'b0;
      ram_req.waddr   = top_next;
      ram_req.wdata   = value;
      ram_req.re      = 1'b0;
      ram_req.raddr   = top_ff;
      info.status     = 1'b0;
      info.data_valid = 1'b0;
      info.evicted    = 1'b0;
      case (operation)
         OP_PUSH: begin
            top_in     = top_next;
            ram_req.we = accept;
            if (is_full) begin
               // new top lands on the oldest slot; RAM reads the old word first
               ram_req.re      = accept;
               ram_req.raddr   = bottom_ff;
               bottom_in       = bottom_next;
               info.data_valid = 1'b1;
               info.evicted    = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP, OP_TAKE: begin
            if (is_empty) begin
               info.status = 1'b1;
            end else begin
               top_in   = top_prev;
               count_in = count_ff - 1'b1;
               if (operation == OP_TAKE) begin
                  ram_req.re      = accept;
                  info.data_valid = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      info.count    = count_in;
      info.full_res = (count_in == CNT_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= PTR_LAST;
         bottom_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/bounded_overwrite_stack_top.sv @@
// Bounded overwrite stack: LIFO of DEPTH words kept in a ring in one RAM.
// Request word: operation (push, pop, take) and value. One response per request:
// status, data_valid, evicted, data_out, count, full_res.
// A push on a full stack overwrites the oldest entry and returns it on data_out
// with evicted set. Take returns the top word; pop discards it. Pop or take on
// an empty stack returns status 1 and changes nothing. Code 3 is a no-op.
// Pipeline: each accepted request passes the read stage, then the output register.
// Throughput: one request per cycle unless stalled; pointers update at accept, so
// each request costs at most one RAM write and one RAM read, and back-to-back
// requests need no forwarding (the RAM is read-first, a push on full reads the
// evicted word in the same cycle it writes).
// Stall: while rsp_port.valid is high and rsp_port.ready is low the output register
// holds; one more request may sit in the read stage, after which req_port.ready drops.
// Reset (synchronous, active high) empties the stack at once; RAM contents are
// never read before written, so no clearing pass is needed.
// Depends on bos_pkg, bos_if, bos_ram, bos_ctrl.
module bounded_overwrite_stack_top (
   input  logic       clock,
   input  logic       reset,
   bos_req_if.sink    req_port,
   bos_rsp_if.source  rsp_port
);
   import bos_pkg::*;

   ram_req_type       ram_req;
   stage_type         info;
   logic [WORD_W-1:0] rdata;
   logic              accept;
   logic              out_free;
   logic              advance;

   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_info_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   stage_type         rsp_info_ff;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;

   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_port.ready = !s1_valid_ff || out_free;
   assign accept         = req_port.valid && req_port.ready;

   bos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_port.operation),
      .value     (req_port.value),
      .ram_req   (ram_req),
      .info      (info)
   );

   bos_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (rdata)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   assign rsp_data_in  = s1_info_ff.data_valid ? rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (advance) begin
         rsp_info_ff <= s1_info_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.status     = rsp_info_ff.status;
   assign rsp_port.data_valid = rsp_info_ff.data_valid;
   assign rsp_port.evicted    = rsp_info_ff.evicted;
   assign rsp_port.data_out   = rsp_data_ff;
   assign rsp_port.count      = rsp_info_ff.count;
   assign rsp_port.full_res   = rsp_info_ff.full_res;

   // a held read stage must block new words, or the RAM output would be lost
   a_hold_blocks_accept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !accept)
      else $error("word accepted while read stage is stalled");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_info_ff.evicted) |->
         (rsp_info_ff.full_res && rsp_info_ff.data_valid && !rsp_info_ff.status))
      else $error("eviction reported without a full stack");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_info_ff.status) |->
         (!rsp_info_ff.data_valid && rsp_data_ff == '0))
      else $error("empty status carries data");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_info_ff.count <= CNT_FULL))
      else $error("count beyond depth");

endmodule
